// ===== design/smcb_pkg.sv =====
// Package for the serial memory command bridge.
// Holds the request and result types, command codes and reply bytes.
// No dependencies.
package smcb_pkg;

    localparam int unsigned MEM_BYTES_DEF = 4096;
    localparam int unsigned HDR_BYTES     = 9;
    localparam int unsigned HDR_CNT_W     = 4;

    localparam logic [7:0] CMD_PING  = 8'h01;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_BULK  = 8'h04;
    localparam logic [7:0] CMD_JUMP  = 8'h05;

    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_request;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rx_refused;
        logic        jump_valid;
        logic [31:0] jump_addr;
    } t_result;

endpackage

// ===== design/smcb_mem.sv =====
// Local byte memory of the bridge: one write port, one registered read port.
// Sweeps zeros through every entry after reset.
// Depends on smcb_pkg.
module smcb_mem
    import smcb_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF,
    localparam int unsigned AW = $clog2(MEM_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    output logic          o_clr_busy
);

    logic [7:0]    r_mem [MEM_BYTES];
    logic [7:0]    r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(MEM_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= 8'h00;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

// ===== design/serial_memory_command_bridge_unit.sv =====
// Serial memory command bridge: top level.
// Gathers 10-byte command packets and acts on the local byte memory.
// Depends on smcb_pkg and smcb_mem.
//
// Input channel: one request per accepted item. mode 0 carries a received
// serial byte, mode 1 offers a transmit send slot.
// Output channel: one result for each request that produces a reply byte,
// a refusal or a jump request; other requests produce nothing.
// A request is taken every cycle while o_in_stall is low; the memory access
// for it (write, or read of one data byte) happens in the cycle it is
// accepted, and the read data returns from the registered memory port in
// the cycle after. A result passes through the stage register r_s1 and
// then into the output register.
// Throughput: one request per cycle while o_in_stall is low.
// Reset: control state clears at once; the memory is then swept to zero,
// one byte a cycle, and o_in_stall stays high until the sweep ends.
// Output stall: the output register and one stage behind it hold results;
// requests are still taken while the stage behind is free or moving.
// MEM_BYTES must be a power of two.
module serial_memory_command_bridge_unit
    import smcb_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_request i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_result  o_out_res
);

    localparam int unsigned AW = $clog2(MEM_BYTES);

    typedef enum logic [1:0] {
        PH_COLLECT,
        PH_BULK,
        PH_READ
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [HDR_CNT_W-1:0]   r_hdr_cnt, n_hdr_cnt;
    logic [7:0]             r_hdr [HDR_BYTES];
    logic [31:0]            r_cursor, n_cursor;
    logic [31:0]            r_remain, n_remain;

    logic                   r_s1_valid, n_s1_valid;
    t_result                r_s1_res, n_s1_res;
    logic                   r_s1_mem, n_s1_mem;
    logic                   r_out_valid;
    t_result                r_out_res;

    logic                   clr_busy;
    logic                   in_fire;
    logic                   s1_move;
    logic                   hdr_wr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [7:0]             wr_data;
    logic                   rd_en;
    logic [7:0]             rd_data;
    logic [31:0]            pkt_addr;
    logic [31:0]            pkt_size;
    t_result                s1_fwd;

    assign pkt_addr = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
    assign pkt_size = {r_hdr[7], r_hdr[6], r_hdr[5], r_hdr[4]};

    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = clr_busy || (r_s1_valid && !s1_move);
    assign in_fire    = i_in_valid && !o_in_stall;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_cursor   = r_cursor;
        n_remain   = r_remain;
        n_s1_valid = r_s1_valid && !s1_move;
        n_s1_res   = r_s1_res;
        n_s1_mem   = r_s1_mem;
        hdr_wr     = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_cursor[AW-1:0];
        wr_data    = i_in_req.rx_byte;
        rd_en      = 1'b0;
        if (in_fire) begin
            n_s1_valid = 1'b0;
            n_s1_mem   = 1'b0;
            n_s1_res   = '0;
            if (i_in_req.mode) begin
                if (r_phase == PH_READ) begin
                    rd_en             = 1'b1;
                    n_cursor          = r_cursor + 32'd1;
                    n_remain          = r_remain - 32'd1;
                    if (r_remain == 32'd1) begin
                        n_phase = PH_COLLECT;
                    end
                    n_s1_valid        = 1'b1;
                    n_s1_mem          = 1'b1;
                    n_s1_res.tx_valid = 1'b1;
                end
            end else begin
                case (r_phase)
                    PH_READ: begin
                        n_s1_valid          = 1'b1;
                        n_s1_res.rx_refused = 1'b1;
                    end
                    PH_BULK: begin
                        wr_en    = 1'b1;
                        n_cursor = r_cursor + 32'd1;
                        n_remain = r_remain - 32'd1;
                        if (r_remain == 32'd1) begin
                            n_phase           = PH_COLLECT;
                            n_s1_valid        = 1'b1;
                            n_s1_res.tx_valid = 1'b1;
                            n_s1_res.tx_byte  = BYTE_ACK;
                        end
                    end
                    default: begin
                        n_phase = PH_COLLECT;
                        if (r_hdr_cnt < HDR_CNT_W'(HDR_BYTES)) begin
                            hdr_wr    = 1'b1;
                            n_hdr_cnt = r_hdr_cnt + 1'b1;
                        end else begin
                            n_hdr_cnt         = '0;
                            n_s1_valid        = 1'b1;
                            n_s1_res.tx_valid = 1'b1;
                            n_s1_res.tx_byte  = BYTE_ACK;
                            case (i_in_req.rx_byte)
                                CMD_PING: begin
                                end
                                CMD_WRITE: begin
                                    wr_en   = 1'b1;
                                    wr_addr = pkt_addr[AW-1:0];
                                    wr_data = r_hdr[8];
                                end
                                CMD_READ: begin
                                    if (pkt_size != 32'd0) begin
                                        n_cursor = pkt_addr;
                                        n_remain = pkt_size;
                                        n_phase  = PH_READ;
                                    end
                                end
                                CMD_BULK: begin
                                    if (pkt_size != 32'd0) begin
                                        n_cursor   = pkt_addr;
                                        n_remain   = pkt_size;
                                        n_phase    = PH_BULK;
                                        n_s1_valid = 1'b0;
                                    end
                                end
                                CMD_JUMP: begin
                                    n_s1_res.jump_valid = 1'b1;
                                    n_s1_res.jump_addr  = pkt_addr;
                                end
                                default: begin
                                    n_s1_res.tx_byte = BYTE_NAK;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        s1_fwd = r_s1_res;
        if (r_s1_mem) begin
            s1_fwd.tx_byte = rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_COLLECT;
            r_hdr_cnt   <= '0;
            r_cursor    <= '0;
            r_remain    <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_cursor   <= n_cursor;
            r_remain   <= n_remain;
            r_s1_valid <= n_s1_valid;
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_res <= n_s1_res;
        r_s1_mem <= n_s1_mem;
        if (s1_move) begin
            r_out_res <= s1_fwd;
        end
        if (hdr_wr) begin
            r_hdr[r_hdr_cnt] <= i_in_req.rx_byte;
        end
    end

    smcb_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_cursor[AW-1:0]),
        .o_rd_data  (rd_data),
        .o_clr_busy (clr_busy)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule
